FILE: rtl/core/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Widths, constants and helper functions for the Taylor-series sine/cosine
// core: internal Q24 formats, per-term divisors and output saturation limits.
// ----------------------------------------------------------------------------
package sct_pkg;

    // Default number of series terms (x, x^3, ... x^(2*TERMS-1))
    localparam int unsigned SCT_TERMS     = 6;

    // Port field widths
    localparam int unsigned ANGLE_W       = 16;   // Q3.13 input angle
    localparam int unsigned VALUE_W       = 18;   // Q4.14 result

    // Q13 -> Q24 alignment and rounding shifts
    localparam int unsigned ANGLE_SHIFT   = 11;
    localparam int unsigned FRAC_SHIFT    = 24;
    localparam int unsigned OUT_SHIFT     = 10;

    // Internal Q24 formats
    localparam int unsigned U_W           = 28;   // signed argument u
    localparam int unsigned MAG_W         = 27;   // |u|
    localparam int unsigned SQ_W          = 2 * MAG_W;
    localparam int unsigned U2_W          = 30;   // round(u*u / 2^24)
    localparam int unsigned Q_W           = 31;   // term magnitude
    localparam int unsigned S_W           = 35;   // signed partial sum
    localparam int unsigned P_W           = Q_W + U2_W;
    localparam int unsigned M_W           = P_W - FRAC_SHIFT;

    // Divide by (2k+2)(2k+3) through an exact reciprocal multiply
    localparam int unsigned DIV_SHIFT     = M_W + 1 + 8;
    localparam int unsigned R_W           = DIV_SHIFT - 2;
    localparam int unsigned LO_W          = (M_W + 1) / 2;
    localparam int unsigned HI_W          = M_W - LO_W;
    localparam int unsigned PH_W          = HI_W + R_W;
    localparam int unsigned PL_W          = LO_W + R_W;
    localparam int unsigned SUM_W         = PL_W + HI_W + 1;

    // Output rounding width
    localparam int unsigned RND_W         = S_W - OUT_SHIFT;

    // round(pi/2 * 2^24)
    localparam logic signed [U_W-1:0] HALF_PI_Q24 = 28'sd26353589;

    // Saturation codes and the magnitudes they stand for
    localparam logic [VALUE_W-1:0] VALUE_MAX_CODE = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VALUE_MIN_CODE = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [RND_W-1:0]   POS_LIMIT      = RND_W'(VALUE_MAX_CODE);
    localparam logic [RND_W-1:0]   NEG_LIMIT      = RND_W'(VALUE_MIN_CODE);

    // Divisor between term k and term k+1
    function automatic int unsigned sct_term_div(input int unsigned k);
        return (2 * k + 2) * (2 * k + 3);
    endfunction

endpackage

FILE: rtl/core/sine_cosine_taylor_core.sv
// ----------------------------------------------------------------------------
// sine_cosine_taylor_core
// Pipelined fixed-point sine/cosine by a truncated Taylor series.
// ----------------------------------------------------------------------------
// Usage:
//   An item (i_action, i_angle) is taken on a clock edge where start is high
//   and busy is low. busy is always low: the pipeline never stalls, so one
//   item can be taken every cycle.
//   i_action = 0 gives sin(angle), 1 gives the series on pi/2 - angle (cos).
//   i_angle is Q3.13 radians with no range reduction; o_value is Q4.14,
//   rounded and saturated.
//   Each result shows on o_value for exactly one cycle with o_valid high,
//   in the order the items came in. Throughput is one item per cycle.
//   The pipeline depth comes from the term chain: three stages per added term
//   (multiply by u^2, reciprocal partial products, sum and shift), plus
//   three stages in front (u, u^2, rounding) and three at the end
//   (last add, rounding, saturation).
//   The receiver cannot hold results off; none is needed here.
//   A synchronous reset clears all valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
module sine_cosine_taylor_core
    import sct_pkg::*;
#(
    parameter int unsigned TERMS = SCT_TERMS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_action,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output logic                      o_valid,
    output logic signed [VALUE_W-1:0] o_value
);

    localparam int unsigned LAST = TERMS - 1;

    // Pipeline never stalls
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Front stage 1: u = angle or pi/2 - angle in Q24, and |u|
    // ------------------------------------------------------------------
    logic                  r_f1_v;
    logic                  r_f1_neg;
    logic [MAG_W-1:0]      r_f1_mag;
    logic signed [U_W-1:0] n_u_scaled;
    logic signed [U_W-1:0] n_u;
    logic signed [U_W-1:0] n_u_abs;

    assign n_u_scaled = {{(U_W-ANGLE_W-ANGLE_SHIFT){i_angle[ANGLE_W-1]}},
                         i_angle, {ANGLE_SHIFT{1'b0}}};
    assign n_u        = i_action ? (HALF_PI_Q24 - n_u_scaled) : n_u_scaled;
    assign n_u_abs    = n_u[U_W-1] ? -n_u : n_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else begin
            r_f1_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_neg <= n_u[U_W-1];
        r_f1_mag <= n_u_abs[MAG_W-1:0];
    end

    // ------------------------------------------------------------------
    // Front stage 2: |u|^2
    // ------------------------------------------------------------------
    logic             r_f2_v;
    logic             r_f2_neg;
    logic [MAG_W-1:0] r_f2_mag;
    logic [SQ_W-1:0]  r_f2_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f2_neg <= r_f1_neg;
        r_f2_mag <= r_f1_mag;
        r_f2_sq  <= {{MAG_W{1'b0}}, r_f1_mag} * {{MAG_W{1'b0}}, r_f1_mag};
    end

    // ------------------------------------------------------------------
    // Front stage 3: u2 = round(u^2 / 2^24); term 0 is u itself
    // ------------------------------------------------------------------
    logic             r_f3_v;
    logic             r_f3_neg;
    logic [MAG_W-1:0] r_f3_mag;
    logic [U2_W-1:0]  r_f3_u2;
    logic [SQ_W-1:0]  n_sq_rnd;

    assign n_sq_rnd = r_f2_sq + (SQ_W'(1) << (FRAC_SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_v <= 1'b0;
        end else begin
            r_f3_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f3_neg <= r_f2_neg;
        r_f3_mag <= r_f2_mag;
        r_f3_u2  <= n_sq_rnd[FRAC_SHIFT+U2_W-1:FRAC_SHIFT];
    end

    // ------------------------------------------------------------------
    // Term boundaries: boundary k carries term k (sign + magnitude), the
    // sum of terms 0..k-1, and u2
    // ------------------------------------------------------------------
    logic                  b_v   [TERMS];
    logic                  b_neg [TERMS];
    logic [Q_W-1:0]        b_q   [TERMS];
    logic signed [S_W-1:0] b_s   [TERMS];
    logic [U2_W-1:0]       b_u2  [TERMS];
    logic signed [S_W-1:0] b_acc [TERMS];

    assign b_v[0]   = r_f3_v;
    assign b_neg[0] = r_f3_neg;
    assign b_q[0]   = {{(Q_W-MAG_W){1'b0}}, r_f3_mag};
    assign b_s[0]   = '0;
    assign b_u2[0]  = r_f3_u2;

    // Sum with the term at each boundary folded in
    for (genvar j = 0; j < TERMS; j++) begin : g_acc
        logic signed [S_W-1:0] q_ext;
        assign q_ext    = $signed({{(S_W-Q_W){1'b0}}, b_q[j]});
        assign b_acc[j] = b_neg[j] ? (b_s[j] - q_ext) : (b_s[j] + q_ext);
    end

    // Term stage registers
    logic                  r_a_v   [TERMS-1];
    logic                  r_a_neg [TERMS-1];
    logic [P_W-1:0]        r_a_p   [TERMS-1];
    logic signed [S_W-1:0] r_a_s   [TERMS-1];
    logic [U2_W-1:0]       r_a_u2  [TERMS-1];

    logic                  r_b_v   [TERMS-1];
    logic                  r_b_neg [TERMS-1];
    logic [PH_W-1:0]       r_b_ph  [TERMS-1];
    logic [PL_W-1:0]       r_b_pl  [TERMS-1];
    logic signed [S_W-1:0] r_b_s   [TERMS-1];
    logic [U2_W-1:0]       r_b_u2  [TERMS-1];

    logic                  r_c_v   [TERMS-1];
    logic                  r_c_neg [TERMS-1];
    logic [Q_W-1:0]        r_c_q   [TERMS-1];
    logic signed [S_W-1:0] r_c_s   [TERMS-1];
    logic [U2_W-1:0]       r_c_u2  [TERMS-1];

    // ------------------------------------------------------------------
    // Term chain: t(k+1) = -round(t(k) * u2 / (d_k * 2^24)), d_k from
    // the package. floor((floor(p/2^24) + d/2) / d) by an exact reciprocal.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < TERMS - 1; k++) begin : g_term
        localparam longint unsigned DIV_K   = longint'(sct_term_div(k));
        localparam longint unsigned RECIP_K =
            ((64'd1 << DIV_SHIFT) + DIV_K - 64'd1) / DIV_K;
        localparam longint unsigned BIAS_K  = (DIV_K / 64'd2) * RECIP_K;
        localparam logic [R_W-1:0]  RECIP   = R_W'(RECIP_K);

        logic [P_W-1:0]   n_p;
        logic [M_W-1:0]   n_m;
        logic [SUM_W-1:0] n_sum;

        // Stage A: |t| * u2, and add t(k) into the sum
        assign n_p = {{(P_W-Q_W){1'b0}}, b_q[k]} * {{(P_W-U2_W){1'b0}}, b_u2[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_v[k] <= 1'b0;
            end else begin
                r_a_v[k] <= b_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_a_neg[k] <= b_neg[k];
            r_a_p[k]   <= n_p;
            r_a_s[k]   <= b_acc[k];
            r_a_u2[k]  <= b_u2[k];
        end

        // Stage B: partial products of floor(p/2^24) with the reciprocal
        assign n_m = r_a_p[k][P_W-1:FRAC_SHIFT];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_v[k] <= 1'b0;
            end else begin
                r_b_v[k] <= r_a_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_b_neg[k] <= r_a_neg[k];
            r_b_ph[k]  <= {{R_W{1'b0}}, n_m[M_W-1:LO_W]} * {{HI_W{1'b0}}, RECIP};
            r_b_pl[k]  <= {{R_W{1'b0}}, n_m[LO_W-1:0]} * {{LO_W{1'b0}}, RECIP};
            r_b_s[k]   <= r_a_s[k];
            r_b_u2[k]  <= r_a_u2[k];
        end

        // Stage C: combine, add the half-divisor bias, take the quotient
        assign n_sum = (SUM_W'(r_b_ph[k]) << LO_W) + SUM_W'(r_b_pl[k])
                     + SUM_W'(BIAS_K);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_v[k] <= 1'b0;
            end else begin
                r_c_v[k] <= r_b_v[k];
            end
        end

        // Next term takes the opposite sign
        always_ff @(posedge i_clk) begin
            r_c_neg[k] <= !r_b_neg[k];
            r_c_q[k]   <= n_sum[DIV_SHIFT+Q_W-1:DIV_SHIFT];
            r_c_s[k]   <= r_b_s[k];
            r_c_u2[k]  <= r_b_u2[k];
        end

        assign b_v[k+1]   = r_c_v[k];
        assign b_neg[k+1] = r_c_neg[k];
        assign b_q[k+1]   = r_c_q[k];
        assign b_s[k+1]   = r_c_s[k];
        assign b_u2[k+1]  = r_c_u2[k];
    end

    // ------------------------------------------------------------------
    // Back stage 1: add the last term
    // ------------------------------------------------------------------
    logic                  r_g1_v;
    logic signed [S_W-1:0] r_g1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_v <= 1'b0;
        end else begin
            r_g1_v <= b_v[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        r_g1_s <= b_acc[LAST];
    end

    // ------------------------------------------------------------------
    // Back stage 2: round |s| / 2^10, ties away from zero
    // ------------------------------------------------------------------
    logic             r_g2_v;
    logic             r_g2_neg;
    logic [RND_W-1:0] r_g2_mag;
    logic [S_W-1:0]   n_s_abs;
    logic [S_W-1:0]   n_s_rnd;

    assign n_s_abs = r_g1_s[S_W-1] ? S_W'(-r_g1_s) : S_W'(r_g1_s);
    assign n_s_rnd = n_s_abs + (S_W'(1) << (OUT_SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g2_v <= 1'b0;
        end else begin
            r_g2_v <= r_g1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g2_neg <= r_g1_s[S_W-1];
        r_g2_mag <= n_s_rnd[S_W-1:OUT_SHIFT];
    end

    // ------------------------------------------------------------------
    // Back stage 3: apply sign and saturate to Q4.14
    // ------------------------------------------------------------------
    logic                      r_g3_v;
    logic signed [VALUE_W-1:0] r_value;
    logic [RND_W-1:0]          n_mag_neg;
    logic [VALUE_W-1:0]        n_value;

    assign n_mag_neg = -r_g2_mag;

    always_comb begin
        if (r_g2_neg) begin
            n_value = (r_g2_mag > NEG_LIMIT) ? VALUE_MIN_CODE
                                             : n_mag_neg[VALUE_W-1:0];
        end else begin
            n_value = (r_g2_mag > POS_LIMIT) ? VALUE_MAX_CODE
                                             : r_g2_mag[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g3_v <= 1'b0;
        end else begin
            r_g3_v <= r_g2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= $signed(n_value);
    end

    assign o_valid = r_g3_v;
    assign o_value = r_value;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sine_cosine_taylor_core. A driver feeds (action,
// angle) items from a queue with random idle gaps and drain pauses. A monitor
// compares every strobed o_value against a bit-exact Q24 series predictor.
// ----------------------------------------------------------------------------
module testbench;
    import sct_pkg::*;

    // Operation select on i_action
    localparam logic ACT_SIN = 1'b0;
    localparam logic ACT_COS = 1'b1;

    // Predictor constants (Q24 pi/2, output limits)
    localparam longint HALF_PI_FX = 64'sd26353589;
    localparam longint VALUE_HI   = 64'sd131071;
    localparam longint VALUE_LO   = -64'sd131072;

    localparam int unsigned PIPE_DEPTH = 3 * SCT_TERMS + 3;
    localparam int unsigned MAX_ERR_PRINTS = 50;

    typedef struct {
        logic                      act;
        logic signed [ANGLE_W-1:0] ang;
        int unsigned               idle;   // idle cycles before this item
        bit                        drain;  // hold until all results are back
    } t_angle_item;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_action = 1'b0;
    logic signed [ANGLE_W-1:0] i_angle = '0;
    logic                      o_valid;
    logic signed [VALUE_W-1:0] o_value;

    t_angle_item               pending_items[$];
    logic signed [VALUE_W-1:0] expected_values[$];
    int unsigned               accepted_count = 0;
    int unsigned               error_count = 0;
    int unsigned               idle_count = 0;
    t_angle_item               next_item;
    logic signed [VALUE_W-1:0] want_value;

    sine_cosine_taylor_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_action (i_action),
        .i_angle  (i_angle),
        .o_valid  (o_valid),
        .o_value  (o_value)
    );

    // 100 MHz clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // p / d rounded to nearest, ties away from zero; d > 0
    function automatic longint round_div(input longint p, input longint unsigned d);
        longint unsigned mag;
        longint unsigned q;
        mag = (p < 0) ? longint'(-p) : longint'(p);
        q = (mag + d / 2) / d;
        return (p < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Expected Q4.14 output for one item
    function automatic logic signed [VALUE_W-1:0] taylor_value(
        input logic act, input logic signed [ANGLE_W-1:0] ang);
        longint          arg;
        longint          arg_sq;
        longint          term;
        longint          acc;
        longint          rounded;
        longint unsigned mag;
        arg = longint'(ang) * 2048;
        if (act == ACT_COS) begin
            arg = HALF_PI_FX - arg;
        end
        mag = (arg < 0) ? longint'(-arg) : longint'(arg);
        arg_sq = longint'((mag * mag + (64'd1 << 23)) >> 24);
        term = arg;
        acc = 0;
        for (int k = 0; k < SCT_TERMS; k++) begin
            acc += term;
            if (k + 1 < SCT_TERMS) begin
                term = -round_div(term * arg_sq,
                                  longint'((2 * k + 2) * (2 * k + 3)) << 24);
            end
        end
        rounded = round_div(acc, 64'd1024);
        if (rounded > VALUE_HI) begin
            rounded = VALUE_HI;
        end
        if (rounded < VALUE_LO) begin
            rounded = VALUE_LO;
        end
        return rounded[VALUE_W-1:0];
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_idle(input bit burst);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 50) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic add_item(input logic act, input logic signed [ANGLE_W-1:0] ang,
                            input int unsigned idle, input bit drain);
        t_angle_item item;
        item.act = act;
        item.ang = ang;
        item.idle = idle;
        item.drain = drain;
        pending_items.push_back(item);
    endtask

    // Driver: record accepted items, then present the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_count = 0;
        end else begin
            if (start && !busy) begin
                expected_values.push_back(taylor_value(i_action, i_angle));
                accepted_count++;
            end
            if (start && busy) begin
                // item not taken yet, keep it on the ports
            end else if (pending_items.size() == 0) begin
                start <= 1'b0;
            end else if (idle_count < pending_items[0].idle ||
                         (pending_items[0].drain && expected_values.size() != 0)) begin
                start <= 1'b0;
                idle_count++;
            end else begin
                next_item = pending_items.pop_front();
                start <= 1'b1;
                i_action <= next_item.act;
                i_angle <= next_item.ang;
                idle_count = 0;
            end
        end
    end

    // Monitor: each strobed result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_values.size() == 0) begin
                error_count++;
                if (error_count <= MAX_ERR_PRINTS) begin
                    $display("%0t: unexpected result: expected none, actual %0d",
                             $realtime, o_value);
                end
            end else begin
                want_value = expected_values.pop_front();
                if (o_value !== want_value) begin
                    error_count++;
                    if (error_count <= MAX_ERR_PRINTS) begin
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $realtime, want_value, o_value);
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic signed [ANGLE_W-1:0] corner_angles[11];
        logic signed [ANGLE_W-1:0] ang;
        int unsigned               total;
        int unsigned               roll;
        bit                        burst;

        // Corners: zero, one LSB, both rails, +/- pi/2, +/- pi, bit patterns
        corner_angles = '{16'sd0, 16'sd1, -16'sd1, 16'sh7FFF, 16'sh8000,
                          16'sd12868, -16'sd12868, 16'sd25736, -16'sd25736,
                          16'sh5555, 16'shAAAA};
        foreach (corner_angles[n]) begin
            add_item(ACT_SIN, corner_angles[n], (n % 3 == 0) ? 2 : 0, n == 6);
            add_item(ACT_COS, corner_angles[n], 0, 1'b0);
        end

        // Random items, in blocks that are either back-to-back or gappy
        burst = 1'b0;
        for (int n = 0; n < 1800; n++) begin
            if (n % 100 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                ang = ANGLE_W'($urandom_range(0, 65535));
            end else if (roll < 85) begin
                // near the rails, where the cosine argument is largest
                ang = (roll[0]) ? ANGLE_W'(16'h8000 + $urandom_range(0, 255))
                                : ANGLE_W'(16'h7FFF - $urandom_range(0, 255));
            end else begin
                // around zero and +/- pi/2
                ang = ANGLE_W'($urandom_range(0, 511) - 256);
                if (roll < 90) begin
                    ang = ang + 16'sd12868;
                end else if (roll < 95) begin
                    ang = ang - 16'sd12868;
                end
            end
            add_item($urandom_range(0, 1) ? ACT_COS : ACT_SIN, ang, pick_idle(burst),
                     n % 400 == 150);
        end
        total = pending_items.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total) @(posedge i_clk);
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/sct_pkg.sv
rtl/core/sine_cosine_taylor_core.sv
sim/testbench.sv
